FILE: hw/rtl/byte_stack_multiwidth_push_pop_top_assert.svh
// ---------------------------------------------------------------------------
// byte stack assertion macros
// shared property forms for the byte stack rtl, clocked on clk, reset rst_n
// ---------------------------------------------------------------------------
`ifndef BYTE_STACK_MULTIWIDTH_PUSH_POP_TOP_ASSERT_SVH
`define BYTE_STACK_MULTIWIDTH_PUSH_POP_TOP_ASSERT_SVH

// same-cycle implication
`define BSMW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSMW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bsmw_pkg.sv
// ---------------------------------------------------------------------------
// bsmw_pkg
// constants, status codes and lane types for the byte stack
// ---------------------------------------------------------------------------
package bsmw_pkg;

  localparam int DEPTH      = 4096;
  localparam int LANES      = 8;
  localparam int LANE_W     = $clog2(LANES);
  localparam int BANK_DEPTH = DEPTH / LANES;
  localparam int ROW_W      = $clog2(BANK_DEPTH);
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 13;
  localparam int VAL_W      = 64;
  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 2;
  localparam int STAT_W     = 2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(DEPTH);

  typedef struct packed {
    logic              go;
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } lane_cmd_t;

  typedef struct packed {
    logic              act;
    logic [LANE_W-1:0] pos;
    logic [BYTE_W-1:0] data;
  } lane_rd_t;

endpackage

FILE: hw/rtl/bsmw_ram.sv
// ---------------------------------------------------------------------------
// bsmw_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module bsmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bsmw_lane.sv
// ---------------------------------------------------------------------------
// bsmw_lane
// one byte bank of the stack: picks its byte of a push or pop and its row
// ---------------------------------------------------------------------------
module bsmw_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bsmw_pkg::LANE_W-1:0] lane_id,
  input  bsmw_pkg::lane_cmd_t        cmd,
  input  logic [bsmw_pkg::VAL_W-1:0] push_value,
  output bsmw_pkg::lane_rd_t         rd
);
  import bsmw_pkg::*;

  logic [LANE_W-1:0] k;
  logic [LANE_W-1:0] nm1;
  logic [LANE_W-1:0] pos;
  logic              active;
  logic [ADDR_W-1:0] addr_full;
  logic [ROW_W-1:0]  row;
  logic [BYTE_W-1:0] wbyte;
  logic [BYTE_W-1:0] rbyte;
  logic              act_r;
  logic              act_nxt;
  logic [LANE_W-1:0] pos_r;
  logic [LANE_W-1:0] pos_nxt;

  // byte offset of this bank within the access, big-endian position in the value
  assign k         = lane_id - cmd.base[LANE_W-1:0];
  assign nm1       = LANE_W'((4'd1 << cmd.size) - 4'd1);
  assign active    = (k <= nm1);
  assign pos       = nm1 - k;
  assign addr_full = cmd.base + ADDR_W'(k);
  assign row       = addr_full[ADDR_W-1:LANE_W];
  assign wbyte     = push_value[{pos, 3'b000} +: BYTE_W];

  bsmw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BANK_DEPTH)
  ) u_bank (
    .clk   (clk),
    .we    (cmd.we && active),
    .re    (cmd.re && active),
    .addr  (row),
    .wdata (wbyte),
    .rdata (rbyte)
  );

  assign act_nxt = cmd.go ? (cmd.re && active) : act_r;
  assign pos_nxt = cmd.go ? pos : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
    pos_r <= pos_nxt;
  end

  assign rd.act  = act_r;
  assign rd.pos  = pos_r;
  assign rd.data = rbyte;

endmodule

FILE: hw/rtl/bsmw_merge.sv
// ---------------------------------------------------------------------------
// bsmw_merge
// places each lane's popped byte at its big-endian position in the value
// ---------------------------------------------------------------------------
module bsmw_merge (
  input  bsmw_pkg::lane_rd_t [bsmw_pkg::LANES-1:0] rd,
  output logic [bsmw_pkg::VAL_W-1:0]               value
);
  import bsmw_pkg::*;

  always_comb begin
    value = '0;
    for (int i = 0; i < LANES; i++) begin
      if (rd[i].act) begin
        value = value | (VAL_W'(rd[i].data) << {rd[i].pos, 3'b000});
      end
    end
  end

endmodule

FILE: hw/rtl/byte_stack_multiwidth_push_pop_top.sv
// an accepted item passes the read stage, then the output register that offers its result
// throughput: one item per cycle, set by the one access per cycle of each byte bank
// an item is taken while an earlier result waits, as long as the read stage can move
// reset: synchronous active-low; byte count clears to zero, limit returns to 4096
// stack memory is not cleared; only bytes pushed since reset are ever read
// ---------------------------------------------------------------------------
// byte_stack_multiwidth_push_pop_top
// byte-addressed lifo stack with 1, 2, 4 or 8 byte big-endian push and pop
// ---------------------------------------------------------------------------
module byte_stack_multiwidth_push_pop_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,    // stack_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // push_value
  input  logic [2:0]  in_tuser,    // req_type, size_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,   // pop_value, bytes_used, zero pad
  output logic [1:0]  out_tuser    // status
);
  import bsmw_pkg::*;

  logic                 accept;
  logic                 is_pop;
  logic [SIZE_W-1:0]    size;
  logic [3:0]           nbytes;
  logic [CNT_W:0]       push_sum;
  logic [CNT_W-1:0]     pop_base;
  logic [CNT_W-1:0]     limit_eff;
  logic                 push_ok;
  logic                 pop_ok;
  logic [STAT_W-1:0]    status;
  lane_cmd_t            cmd;
  lane_rd_t [LANES-1:0] lane_rd;
  logic [VAL_W-1:0]     merged;
  logic                 p1_move;

  logic [CNT_W-1:0]  limit_r,      limit_nxt;
  logic [CNT_W-1:0]  used_r,       used_nxt;
  logic              p1_valid_r,   p1_valid_nxt;
  logic [STAT_W-1:0] p1_status_r,  p1_status_nxt;
  logic [CNT_W-1:0]  p1_used_r,    p1_used_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r,  out_value_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_used_r,   out_used_nxt;

  assign cfg_ready = 1'b1;
  assign limit_nxt = (cfg_valid && cfg_ready) ? cfg_data : limit_r;

  assign p1_move   = p1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !p1_valid_r || !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign is_pop    = (in_tuser[0] == REQ_POP);
  assign size      = in_tuser[2:1];
  assign nbytes    = 4'd1 << size;
  assign push_sum  = {1'b0, used_r} + (CNT_W+1)'(nbytes);
  assign pop_base  = used_r - CNT_W'(nbytes);
  assign limit_eff = (limit_r > LIMIT_RESET) ? LIMIT_RESET : limit_r;
  assign push_ok   = (push_sum <= {1'b0, limit_eff});
  assign pop_ok    = (used_r >= CNT_W'(nbytes));

  always_comb begin
    used_nxt = used_r;
    status   = ST_OK;
    if (is_pop) begin
      if (pop_ok) begin
        used_nxt = pop_base;
      end else begin
        status = ST_UNDERFLOW;
      end
    end else begin
      if (push_ok) begin
        used_nxt = push_sum[CNT_W-1:0];
      end else begin
        status = ST_OVERFLOW;
      end
    end
    if (!accept) begin
      used_nxt = used_r;
    end
  end

  assign cmd.go   = accept;
  assign cmd.we   = accept && !is_pop && push_ok;
  assign cmd.re   = accept && is_pop && pop_ok;
  assign cmd.base = is_pop ? pop_base[ADDR_W-1:0] : used_r[ADDR_W-1:0];
  assign cmd.size = size;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bsmw_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .lane_id    (LANE_W'(g)),
      .cmd        (cmd),
      .push_value (in_tdata),
      .rd         (lane_rd[g])
    );
  end

  bsmw_merge u_merge (
    .rd    (lane_rd),
    .value (merged)
  );

  assign p1_valid_nxt   = accept ? 1'b1 : (p1_move ? 1'b0 : p1_valid_r);
  assign p1_status_nxt  = accept ? status : p1_status_r;
  assign p1_used_nxt    = accept ? used_nxt : p1_used_r;

  assign out_valid_nxt  = p1_move ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  assign out_value_nxt  = p1_move ? merged : out_value_r;
  assign out_status_nxt = p1_move ? p1_status_r : out_status_r;
  assign out_used_nxt   = p1_move ? p1_used_r : out_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      used_r      <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      used_r      <= used_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    p1_status_r  <= p1_status_nxt;
    p1_used_r    <= p1_used_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_used_r, out_value_r};
  assign out_tuser  = out_status_r;

`include "byte_stack_multiwidth_push_pop_top_assert.svh"

  `BSMW_ASSERT_NOW(a_used_in_depth, 1'b1, used_r <= LIMIT_RESET, "byte count beyond depth")
  `BSMW_ASSERT_NEXT(a_overflow_keeps, accept && !is_pop && !push_ok, used_r == $past(used_r), "overflow changed count")
  `BSMW_ASSERT_NOW(a_underflow_zero, out_valid_r && out_status_r == ST_UNDERFLOW, out_value_r == '0, "underflow value not zero")
  `BSMW_ASSERT_NEXT(a_p1_holds, p1_valid_r && out_valid_r && !out_tready, p1_valid_r, "read stage lost item")

endmodule

FILE: verif/tb_byte_stack_multiwidth_push_pop_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_byte_stack_multiwidth_push_pop_top
// drives push and pop items of every width into the byte stack and checks
// each result against a byte-level stack model kept in the testbench; the
// stack limit is moved through several settings between phases, including
// zero, the memory depth, a value above it and values below the bytes held
// ---------------------------------------------------------------------------
module tb_byte_stack_multiwidth_push_pop_top;
  import bsmw_pkg::*;

  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic              req;
    logic [SIZE_W-1:0] size;
    logic [VAL_W-1:0]  value;
  } stack_req_t;

  typedef struct {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  used;
  } stack_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;    // push_value
  logic [2:0]  in_tuser = '0;    // req_type, size_code
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;        // pop_value, bytes_used, zero pad
  logic [1:0]  out_tuser;        // status

  stack_req_t pending_reqs[$];
  stack_rsp_t expected_rsps[$];
  stack_req_t in_flight;

  bit [7:0]         stack_mem [DEPTH];
  int               stack_held = 0;
  logic [CNT_W-1:0] stack_limit_q = LIMIT_RESET;

  int plan_held = 0;
  int plan_cap = DEPTH;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int errors = 0;
  int stall_cnt = 0;

  byte_stack_multiwidth_push_pop_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic stack_rsp_t apply_request(stack_req_t r);
    stack_rsp_t rsp;
    int n;
    int cap;
    n = 1 << r.size;
    cap = (stack_limit_q < DEPTH) ? int'(stack_limit_q) : DEPTH;
    rsp.value = '0;
    rsp.status = ST_OK;
    if (r.req == REQ_PUSH) begin
      if (stack_held + n > cap) begin
        rsp.status = ST_OVERFLOW;
      end else begin
        for (int i = 0; i < n; i++)
          stack_mem[stack_held + i] = r.value[8 * (n - 1 - i) +: 8];
        stack_held += n;
      end
    end else if (stack_held < n) begin
      rsp.status = ST_UNDERFLOW;
    end else begin
      stack_held -= n;
      for (int i = 0; i < n; i++)
        rsp.value = {rsp.value[VAL_W-9:0], stack_mem[stack_held + i]};
    end
    rsp.used = stack_held[CNT_W-1:0];
    return rsp;
  endfunction

  // queue an item and follow the byte count it leads to
  task automatic add_req(input logic req, input logic [SIZE_W-1:0] size,
                         input logic [VAL_W-1:0] value);
    stack_req_t r;
    int n;
    r.req = req;
    r.size = size;
    r.value = value;
    n = 1 << size;
    if (req == REQ_PUSH) begin
      if (plan_held + n <= plan_cap) plan_held += n;
    end else if (plan_held >= n) begin
      plan_held -= n;
    end
    pending_reqs.push_back(r);
  endtask

  // sampled at the falling edge so the clocked blocks have all moved
  task automatic settle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_rsps.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limit(input logic [CNT_W-1:0] lim);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    do @(posedge clk);
    while (!cfg_ready);
    stack_limit_q = lim;
    cfg_valid <= 1'b0;
    plan_cap = (lim < DEPTH) ? int'(lim) : DEPTH;
  endtask

  // random walk of pushes and pops steered toward a target fill level
  task automatic run_phase(input logic [CNT_W-1:0] lim, input int target, input int count,
                           input int idle_pct);
    int fill_gap;
    int push_pct;
    logic [SIZE_W-1:0] size;
    set_limit(lim);
    in_idle_pct = idle_pct;
    out_idle_pct = idle_pct;
    for (int k = 0; k < count; k++) begin
      fill_gap = target - plan_held;
      push_pct = (fill_gap > 16) ? 95 : (fill_gap < -16) ? 5 : 50;
      if ((plan_held > 256 || target > 256) && $urandom_range(0, 99) < 75)
        size = SIZE_W'(3);
      else
        size = SIZE_W'($urandom_range(0, 3));
      add_req(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP, size,
              {$urandom, $urandom});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_rsps.push_back(apply_request(in_flight));
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(1, 19) - 1;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_flight = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= in_flight.value;
          in_tuser <= {in_flight.size, in_flight.req};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    stack_rsp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: value %h status %0d used %0d",
                   $time, out_tdata[63:0], out_tuser, out_tdata[76:64]);
        end else begin
          e = expected_rsps.pop_front();
          if (out_tdata[63:0] !== e.value) begin
            errors++;
            $display("%0t: pop value expected %h actual %h", $time, e.value,
                     out_tdata[63:0]);
          end
          if (out_tuser !== e.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_tuser);
          end
          if (out_tdata[76:64] !== e.used) begin
            errors++;
            $display("%0t: bytes used expected %0d actual %0d", $time, e.used,
                     out_tdata[76:64]);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (out_idle_pct > 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(1, 19) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        stall_cnt = 0;
      else
        stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 10;
    out_idle_pct = 10;

    // empty stack, reset limit
    add_req(REQ_POP, 2'd0, 64'h0);
    add_req(REQ_POP, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(REQ_PUSH, 2'd0, 64'hFFFF_FFFF_FFFF_FF5A);
    add_req(REQ_POP, 2'd1, 64'h0);
    add_req(REQ_PUSH, 2'd1, 64'h1234_5678_9ABC_BEEF);
    add_req(REQ_PUSH, 2'd2, 64'hDEAD_0000_0123_4567);
    add_req(REQ_PUSH, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(REQ_PUSH, 2'd3, 64'h0);
    add_req(REQ_POP, 2'd3, 64'h0);
    add_req(REQ_POP, 2'd3, 64'h0);
    add_req(REQ_POP, 2'd2, 64'h0);
    add_req(REQ_POP, 2'd1, 64'h0);
    add_req(REQ_POP, 2'd0, 64'h0);
    add_req(REQ_POP, 2'd0, 64'h0);
    // pops of other widths than the push
    add_req(REQ_PUSH, 2'd3, 64'h8000_0000_0000_0001);
    add_req(REQ_POP, 2'd0, 64'h0);
    add_req(REQ_POP, 2'd1, 64'h0);
    add_req(REQ_POP, 2'd2, 64'h0);
    add_req(REQ_POP, 2'd0, 64'h0);
    add_req(REQ_PUSH, 2'd2, 64'h5A5A_A5A5_A5A5_5A5A);
    add_req(REQ_POP, 2'd3, 64'h0);
    add_req(REQ_POP, 2'd2, 64'h0);

    // limit above depth, fill up to the top and push against it
    run_phase(13'd8191, DEPTH, 680, 10);
    run_phase(13'd4096, DEPTH, 100, 0);
    // limit far below the bytes held, then no room at all
    run_phase(13'd37, 0, 680, 25);
    run_phase(13'd0, 0, 80, 5);
    run_phase(CNT_W'($urandom_range(1, 64)), $urandom_range(0, 48), 110, 15);
    run_phase(CNT_W'($urandom_range(1, 64)), $urandom_range(0, 48), 110, 15);
    run_phase(13'd4096, 64, 200, 0);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
